@@ rtl/core/cma_pkg.sv @@
// shared constants, types and command/status bundles of the centered moving average unit
package cma_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WIN_W      = 5;
  localparam int HALF_W     = 4;
  localparam int MAX_WINDOW = 31;
  localparam int PTR_W      = 5;
  localparam int SUM_W      = 21;
  localparam int MAG_W      = 20;
  localparam int DIV_STEPS  = 20;
  localparam int STEP_W     = 5;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_WINDOW - 1);
  localparam logic [PTR_W-1:0] SEEN_SAT  = PTR_W'(MAX_WINDOW);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);
  localparam logic             REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic accept;
    logic setup;
    logic read;
    logic div_load;
    logic div_step;
    logic emit;
  } cma_cmd_t;

  typedef struct packed {
    logic pos_any;
    logic read_last;
    logic div_done;
    logic out_free;
    logic more;
  } cma_stat_t;

endpackage

@@ rtl/core/cma_ctrl.sv @@
// sequencing state machine of the centered moving average unit
module cma_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cma_pkg::cma_stat_t stat,
  output cma_pkg::cma_cmd_t  cmd
);
  import cma_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_START = 8'b0000_0010,
    ST_SETUP = 8'b0000_0100,
    ST_READ  = 8'b0000_1000,
    ST_DRAIN = 8'b0001_0000,
    ST_DLOAD = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = stat.pos_any ? ST_SETUP : ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read = 1'b1;
        if (stat.read_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.more ? ST_SETUP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/cma_dpath.sv @@
// sample ring, window accumulator, serial divider and output register
module cma_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cma_pkg::cma_cmd_t             cmd,
  output cma_pkg::cma_stat_t            stat,
  input  logic [cma_pkg::WIN_W-1:0]     window_size,
  input  logic signed [cma_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [cma_pkg::SAMPLE_W-1:0] out_average,
  output logic                          out_last_result
);
  import cma_pkg::*;

  logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  seen_r;
  logic [HALF_W-1:0] h_r;
  logic [PTR_W-1:0]  newest_r;
  logic              last_r;
  logic [PTR_W-1:0]  d_r;
  logic [PTR_W-1:0]  hi_r;
  logic [PTR_W-1:0]  b_r;
  logic [PTR_W-1:0]  raddr_r;
  logic              rd_vld_r;
  logic [SAMPLE_W-1:0] rdata_r;
  logic signed [SUM_W-1:0] acc_r;
  logic              neg_r;
  logic [MAG_W-1:0]  quo_r;
  logic [PTR_W-1:0]  rem_r;
  logic [PTR_W-1:0]  divisor_r;
  logic [STEP_W-1:0] div_cnt_r;
  logic              out_valid_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic              out_last_r;

  logic [PTR_W-1:0]  wptr_nxt;
  logic [PTR_W-1:0]  newest_nxt;
  logic [HALF_W-1:0] h_nxt;
  logic [PTR_W-1:0]  d0_nxt;
  logic [PTR_W-1:0]  reach;
  logic [PTR_W-1:0]  hi_nxt;
  logic [SUM_W-1:0]  acc_abs;
  logic [PTR_W:0]    rem_sh;
  logic [PTR_W+1:0]  trial;
  logic [SAMPLE_W-1:0] quo_lo;

  always_comb begin
    wptr_nxt   = wptr_r;
    if (seen_r != '0) begin
      wptr_nxt = (wptr_r == LAST_SLOT) ? '0 : wptr_r + 1'b1;
    end
    newest_nxt = (seen_r == SEEN_SAT) ? LAST_SLOT : seen_r;
    h_nxt      = window_size[WIN_W-1:1];
    d0_nxt     = ({1'b0, h_nxt} <= newest_nxt) ? {1'b0, h_nxt} : newest_nxt;
    reach      = d_r + {1'b0, h_r};
    hi_nxt     = (reach <= newest_r) ? reach : newest_r;
    acc_abs    = acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);
    rem_sh     = {rem_r, quo_r[MAG_W-1]};
    trial      = {1'b0, rem_sh} - {2'b00, divisor_r};
    quo_lo     = quo_r[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_mem[wptr_nxt] <= in_sample;
    end
    if (cmd.read) begin
      rdata_r <= ring_mem[raddr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      h_r      <= h_nxt;
      newest_r <= newest_nxt;
      last_r   <= in_last_sample;
      d_r      <= d0_nxt;
    end else if (cmd.emit) begin
      d_r <= d_r - 1'b1;
    end
    if (cmd.setup) begin
      hi_r    <= hi_nxt;
      b_r     <= '0;
      raddr_r <= wptr_r;
    end else if (cmd.read) begin
      b_r     <= b_r + 1'b1;
      raddr_r <= (raddr_r == '0) ? LAST_SLOT : raddr_r - 1'b1;
    end
    if (cmd.setup) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      acc_r <= acc_r + SUM_W'(signed'(rdata_r));
    end
    if (cmd.div_load) begin
      neg_r     <= acc_r[SUM_W-1];
      quo_r     <= acc_abs[MAG_W-1:0];
      rem_r     <= '0;
      divisor_r <= hi_r + 1'b1;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[PTR_W+1]) begin
        rem_r <= trial[PTR_W-1:0];
        quo_r <= {quo_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[PTR_W-1:0];
        quo_r <= {quo_r[MAG_W-2:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.emit) begin
      out_avg_r  <= neg_r ? SAMPLE_W'(-quo_lo) : quo_lo;
      out_last_r <= last_r && (d_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      seen_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.read;
      if (cmd.accept) begin
        wptr_r <= wptr_nxt;
        if (in_last_sample) begin
          seen_r <= '0;
        end else if (seen_r != SEEN_SAT) begin
          seen_r <= seen_r + 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.pos_any   = last_r || ({1'b0, h_r} <= newest_r);
  assign stat.read_last = (b_r == hi_r);
  assign stat.div_done  = (div_cnt_r == STEP_W'(DIV_STEPS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.more      = last_r && (d_r != '0);

  assign out_valid       = out_valid_r;
  assign out_average     = out_avg_r;
  assign out_last_result = out_last_r;

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while pending");

  a_acc_done_before_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |-> !rd_vld_r)
    else $error("divider loaded before window sum complete");

  a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read |-> (b_r <= hi_r))
    else $error("ring read beyond window");

endmodule

@@ rtl/core/centered_moving_average_unit.sv @@
// top level of the centered moving average unit: config register, controller and datapath
//
// Input channel in_valid/in_ready carries one signed sample and a flag marking
// the last sample of a data set. Output channel out_valid/out_ready carries one
// average per position, truncated toward zero, with a flag on the final one.
// Results lag the input by half the window (window_size / 2); the last sample
// flushes all pending positions. Register window_size sits at address 0 of
// the APB port and resets to 3; write it only while the unit is idle.
// A new request is taken only in the idle state. A position of c samples
// (c up to 31) takes one ring read per sample from the single ring port plus
// a 20-step shift-subtract divider. A request is finished, and the next one
// can be taken, once its last result is loaded into the output register; a
// request that yields no result goes straight back to idle.
// A finished result waits in the output register while the next request is
// taken; when the receiver stalls, the unit stops only once another result
// is ready to go out. Synchronous reset clears the control state and the set
// in progress; ring contents are not cleared and are never read unwritten.
module centered_moving_average_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cma_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cma_pkg::SAMPLE_W-1:0]  out_average,
  output logic                                 out_last_result,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cma_pkg::ADDR_W-1:0]           paddr,
  input  logic [cma_pkg::DATA_W-1:0]           pwdata,
  output logic [cma_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);
  import cma_pkg::*;

  logic [WIN_W-1:0] window_size_r;
  cma_cmd_t         cmd;
  cma_stat_t        stat;
  logic             reg_hit;

  assign reg_hit = (paddr[ADDR_W-1] == REG_WINDOW_SIZE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? DATA_W'(window_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      window_size_r <= pwdata[WIN_W-1:0];
    end
  end

  cma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cma_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .window_size     (window_size_r),
    .in_sample       (in_sample),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_average     (out_average),
    .out_last_result (out_last_result)
  );

endmodule
